[rtl/earliest_free_worker_scheduler_defines.svh]
// assertion helpers for the earliest free worker scheduler
`ifndef EARLIEST_FREE_WORKER_SCHEDULER_DEFINES_SVH
`define EARLIEST_FREE_WORKER_SCHEDULER_DEFINES_SVH

// same-cycle implication, held off while in reset
`define EFWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("efws check failed");

// next-cycle implication, held off while in reset
`define EFWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("efws check failed");

`endif

[rtl/efws_pkg.sv]
`default_nettype none

package efws_pkg;

  localparam int MAX_WORKERS = 64;
  localparam int TIME_WIDTH  = 48;

  localparam int COUNT_W = 7;
  localparam int DUR_W   = 32;
  localparam int OIDX_W  = 6;
  localparam int START_W = 48;

  localparam int IDX_W  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int NCLG   = $clog2(MAX_WORKERS + 1);
  localparam int N_W    = (NCLG > COUNT_W) ? NCLG : COUNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD
  } efws_state_t;

  typedef struct packed {
    logic             go;
    logic [DUR_W-1:0] duration;
    logic [N_W-1:0]   workers;
  } efws_cmd_t;

  typedef struct packed {
    logic               valid;
    logic [OIDX_W-1:0]  worker_index;
    logic [START_W-1:0] start_tick;
  } efws_res_t;

endpackage

`default_nettype wire

[rtl/efws_job_if.sv]
`default_nettype none

interface efws_job_if;
  logic                      valid;
  logic                      ready;
  logic [efws_pkg::DUR_W-1:0] job_duration;

  modport source (output valid, output job_duration, input ready);
  modport sink (input valid, input job_duration, output ready);
endinterface

`default_nettype wire

[rtl/efws_res_if.sv]
`default_nettype none

interface efws_res_if;
  logic                         valid;
  logic                         ready;
  logic [efws_pkg::OIDX_W-1:0]  worker_index;
  logic [efws_pkg::START_W-1:0] start_tick;

  modport source (output valid, output worker_index, output start_tick, input ready);
  modport sink (input valid, input worker_index, input start_tick, output ready);
endinterface

`default_nettype wire

[rtl/earliest_free_worker_scheduler.sv]
// earliest free worker scheduler
// in_job carries one job duration per item; out_res returns, for each job, the
// index of the worker given the job and the tick at which it starts.
// both channels use valid/ready; an item moves when valid and ready are high.
// cfg_we/cfg_wdata write the worker count (0 acts as 1, above 64 acts as 64);
// write it only while no job is in flight.
// each job is taken, then the free-time memory is streamed through the single
// compare unit (one read a cycle, each compared in the cycle after its read),
// then the duration is added and written back; in_job.ready is low meanwhile.
// the result sits in an output register; the next job is accepted while it
// waits, but its write-back stalls until out_res has taken the earlier one.
// synchronous reset clears every free time to zero (per-entry valid bits),
// sets the worker count to one and empties the output register.
`default_nettype none

`include "earliest_free_worker_scheduler_defines.svh"

module earliest_free_worker_scheduler (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  efws_job_if.sink                           in_job,
  efws_res_if.source                         out_res,
  input  wire logic                          cfg_we,
  input  wire logic [efws_pkg::COUNT_W-1:0]  cfg_wdata
);

  localparam int NW = efws_pkg::N_W;

  logic [efws_pkg::COUNT_W-1:0]  cfg_r;
  logic [NW-1:0]                 cnt_ext;
  logic [NW-1:0]                 workers;
  efws_pkg::efws_cmd_t           cmd;
  efws_pkg::efws_res_t           res;
  logic                          core_idle;
  logic                          out_free;

  logic                          out_valid_r;
  logic [efws_pkg::OIDX_W-1:0]   out_idx_r;
  logic [efws_pkg::START_W-1:0]  out_start_r;

  assign cnt_ext = NW'(cfg_r);

  always_comb begin
    if (cnt_ext == '0) begin
      workers = NW'(1);
    end else if (cnt_ext > NW'(efws_pkg::MAX_WORKERS)) begin
      workers = NW'(efws_pkg::MAX_WORKERS);
    end else begin
      workers = cnt_ext;
    end
  end

  assign cmd.go       = in_job.valid && core_idle;
  assign cmd.duration = in_job.job_duration;
  assign cmd.workers  = workers;
  assign in_job.ready = core_idle;
  assign out_free     = !out_valid_r || out_res.ready;

  efws_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .out_free (out_free),
    .res      (res),
    .idle     (core_idle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= efws_pkg::COUNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (res.valid) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_idx_r   <= res.worker_index;
      out_start_r <= res.start_tick;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.worker_index = out_idx_r;
  assign out_res.start_tick   = out_start_r;

  // a result is only handed over when the output register can take it
  `EFWS_ASSERT_NOW(a_res_room, clk, rst_n, res.valid, !out_valid_r || out_res.ready)
  // a handed-over result shows up on the output next cycle
  `EFWS_ASSERT_NEXT(a_res_shown, clk, rst_n, res.valid, out_res.valid)
  // an accepted job keeps the input closed while it is scanned
  `EFWS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_job.valid && in_job.ready, !in_job.ready)

endmodule

`default_nettype wire

[rtl/efws_core.sv]
`default_nettype none

module efws_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire efws_pkg::efws_cmd_t cmd,
  input  wire logic                out_free,
  output efws_pkg::efws_res_t      res,
  output logic                     idle
);

  localparam int TW = efws_pkg::TIME_WIDTH;
  localparam int IW = efws_pkg::IDX_W;
  localparam int NW = efws_pkg::N_W;

  efws_pkg::efws_state_t state_r, state_nxt;

  logic [NW-1:0]               cnt_r, cnt_nxt;
  logic [NW-1:0]               n_r, n_nxt;
  logic [efws_pkg::DUR_W-1:0]  dur_r, dur_nxt;
  logic [IW-1:0]               best_idx_r, best_idx_nxt;
  logic [TW-1:0]               best_val_r, best_val_nxt;

  logic [TW-1:0]                  mem [efws_pkg::MAX_WORKERS];
  logic [efws_pkg::MAX_WORKERS-1:0] vld_r;
  logic [TW-1:0]                  rd_data_r;
  logic                           rd_vld_r;
  logic [IW-1:0]                  rd_addr;
  logic [TW-1:0]                  cur_val;
  logic [IW-1:0]                  cur_idx;
  logic [TW:0]                    sum;
  logic [TW-1:0]                  upd_val;
  logic                           wr_en;
  logic [TW+efws_pkg::START_W-1:0] start_ext;
  logic [IW+efws_pkg::OIDX_W-1:0]  idx_ext;

  assign rd_addr   = cnt_r[IW-1:0];
  assign cur_val   = rd_vld_r ? rd_data_r : '0;
  assign cur_idx   = IW'(cnt_r - NW'(1));
  assign sum       = {1'b0, best_val_r} + (TW+1)'(dur_r);
  assign upd_val   = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
  assign start_ext = {{efws_pkg::START_W{1'b0}}, best_val_r};
  assign idx_ext   = {{efws_pkg::OIDX_W{1'b0}}, best_idx_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      efws_pkg::ST_IDLE: begin
        if (cmd.go) begin
          state_nxt = efws_pkg::ST_SCAN;
        end
      end
      efws_pkg::ST_SCAN: begin
        if (cnt_r == n_r) begin
          state_nxt = efws_pkg::ST_UPD;
        end
      end
      efws_pkg::ST_UPD: begin
        if (out_free) begin
          state_nxt = efws_pkg::ST_IDLE;
        end
      end
      default: state_nxt = efws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt          = cnt_r;
    n_nxt            = n_r;
    dur_nxt          = dur_r;
    best_idx_nxt     = best_idx_r;
    best_val_nxt     = best_val_r;
    wr_en            = 1'b0;
    idle             = 1'b0;
    res.valid        = 1'b0;
    res.worker_index = idx_ext[efws_pkg::OIDX_W-1:0];
    res.start_tick   = start_ext[efws_pkg::START_W-1:0];
    case (state_r)
      efws_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (cmd.go) begin
          cnt_nxt = '0;
          n_nxt   = cmd.workers;
          dur_nxt = cmd.duration;
        end
      end
      efws_pkg::ST_SCAN: begin
        cnt_nxt = cnt_r + NW'(1);
        // compare the entry read in the previous cycle
        if (cnt_r != '0) begin
          if ((cnt_r == NW'(1)) || (cur_val < best_val_r)) begin
            best_idx_nxt = cur_idx;
            best_val_nxt = cur_val;
          end
        end
      end
      efws_pkg::ST_UPD: begin
        res.valid = out_free;
        wr_en     = out_free;
      end
      default: begin
        idle = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= efws_pkg::ST_IDLE;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        vld_r[best_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    n_r        <= n_nxt;
    dur_r      <= dur_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    rd_vld_r   <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[best_idx_r] <= upd_val;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[bench/earliest_free_worker_scheduler_tb.sv]
`timescale 1ns / 100ps

module earliest_free_worker_scheduler_tb;

  localparam int OIDX_W = efws_pkg::OIDX_W;
  localparam int START_W = efws_pkg::START_W;
  localparam int COUNT_W = efws_pkg::COUNT_W;
  localparam int DUR_W = efws_pkg::DUR_W;
  localparam int TIME_WIDTH = efws_pkg::TIME_WIDTH;
  localparam int MAX_WORKERS = efws_pkg::MAX_WORKERS;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_JOBS = 50;
  localparam int HOLD_CYCLES = 400;
  localparam int FILL_JOBS = 10;

  typedef struct packed {
    logic [OIDX_W-1:0]  worker;
    logic [START_W-1:0] start;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  efws_job_if job_ch();
  efws_res_if res_ch();

  earliest_free_worker_scheduler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_job    (job_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  logic [DUR_W-1:0] pending_jobs[$];
  grant_t expected_grants[$];
  logic [COUNT_W-1:0] worker_limit;
  logic [TIME_WIDTH-1:0] free_tick[MAX_WORKERS];

  int jobs_queued = 0;
  int jobs_accepted = 0;
  int grants_seen = 0;
  int saturated_grants = 0;
  int count_writes = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int recv_stall = 0;
  bit job_fire;
  bit idle_enable;
  bit pressure_go;
  bit hold_out = 1'b0;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 20);
    else return $urandom_range(30, 150);
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2, 3, 4: return DUR_W'($urandom_range(1, 20));
      5, 6: return DUR_W'($urandom_range(0, 1000));
      7: return DUR_W'($urandom);
      8: return '1 - DUR_W'($urandom_range(0, 15));
      default: return DUR_W'(1) << $urandom_range(0, DUR_W - 1);
    endcase
  endfunction

  // earliest free worker, lowest index on ties, free time saturates
  function automatic grant_t book_job(logic [DUR_W-1:0] dur);
    int n;
    int pick;
    logic [TIME_WIDTH:0] sum;
    grant_t g;
    n = (worker_limit == 0) ? 1 : ((worker_limit > MAX_WORKERS) ? MAX_WORKERS : worker_limit);
    pick = 0;
    for (int w = 1; w < n; w++) begin
      if (free_tick[w] < free_tick[pick]) pick = w;
    end
    g.worker = OIDX_W'(pick);
    g.start = START_W'(free_tick[pick]);
    sum = {1'b0, free_tick[pick]} + dur;
    free_tick[pick] = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
    return g;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_job(input logic [DUR_W-1:0] dur);
    pending_jobs.push_back(dur);
    jobs_queued++;
  endtask

  task automatic drain();
    while (jobs_accepted != jobs_queued || expected_grants.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] value);
    @(negedge clk);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    count_writes++;
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      job_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (!job_ch.valid || job_fire) begin
      if (send_gap != 0 || pending_jobs.size() == 0) begin
        job_ch.valid <= 1'b0;
        if (send_gap != 0) send_gap <= send_gap - 1;
      end else begin
        job_ch.valid <= 1'b1;
        job_ch.job_duration <= pending_jobs.pop_front();
        send_gap <= idle_enable ? idle_len() : 0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      recv_stall <= 0;
    end else if (hold_out) begin
      res_ch.ready <= 1'b0;
    end else if (recv_stall != 0) begin
      res_ch.ready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else begin
      res_ch.ready <= 1'b1;
      recv_stall <= idle_enable ? idle_len() : 0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      job_fire <= 1'b0;
      worker_limit = COUNT_W'(1);
      for (int w = 0; w < MAX_WORKERS; w++) free_tick[w] = '0;
    end else begin
      job_fire <= job_ch.valid && job_ch.ready;
      if (cfg_we) worker_limit = cfg_wdata;
      if (res_ch.valid && res_ch.ready) begin
        grants_seen++;
        if (res_ch.start_tick == '1) saturated_grants++;
        if (expected_grants.size() == 0) begin
          report_mismatch($sformatf("unexpected grant worker %0d start %0d",
                                    res_ch.worker_index, res_ch.start_tick));
        end else begin
          grant_t g;
          g = expected_grants.pop_front();
          if (res_ch.worker_index !== g.worker)
            report_mismatch($sformatf("grant %0d worker_index %0d, want %0d",
                                      grants_seen, res_ch.worker_index, g.worker));
          if (res_ch.start_tick !== g.start)
            report_mismatch($sformatf("grant %0d start_tick %0d, want %0d",
                                      grants_seen, res_ch.start_tick, g.start));
        end
      end
      if (job_ch.valid && job_ch.ready) begin
        expected_grants.push_back(book_job(job_ch.job_duration));
        jobs_accepted++;
      end
      if ((job_ch.valid && job_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out <= 1'b0;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [COUNT_W-1:0] settings[10];
    job_ch.valid = 1'b0;
    job_ch.job_duration = '0;
    res_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    idle_enable = 1'b0;
    pressure_go = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset count of one worker
    queue_job('0);
    queue_job('1);
    queue_job(DUR_W'(1));
    queue_job(32'h8000_0000);
    queue_job(32'h7fff_ffff);
    queue_job('0);
    drain();
    // zero acts as one worker
    write_count('0);
    queue_job(DUR_W'(5));
    queue_job('0);
    queue_job(DUR_W'(3));
    drain();
    // above the maximum, clamps to all workers
    write_count('1);
    queue_job(DUR_W'(1));
    queue_job(DUR_W'(1));
    queue_job('0);
    queue_job(DUR_W'(2));
    queue_job('1);
    queue_job('0);
    queue_job(DUR_W'(1));
    queue_job(DUR_W'(7));
    drain();
    // ties go to the lowest index
    write_count(COUNT_W'(3));
    queue_job(DUR_W'(1));
    queue_job(DUR_W'(1));
    queue_job(DUR_W'(1));
    queue_job('1);
    drain();

    settings = '{7'd64, 7'd2, 7'd65, 7'd7, 7'd33, 7'd1, 7'd0, 7'd127, 7'd16,
                 COUNT_W'($urandom_range(0, 127))};
    for (int p = 0; p < 10; p++) begin
      write_count(settings[p]);
      idle_enable = (p % 3) != 2;
      if (p == 1) begin
        idle_enable = 1'b0;
        pressure_go = 1'b1;
      end
      for (int k = 0; k < PHASE_JOBS; k++) queue_job(pick_duration());
      drain();
    end

    // one worker with the longest jobs back to back
    write_count(COUNT_W'(1));
    idle_enable = 1'b0;
    for (int k = 0; k < FILL_JOBS; k++) queue_job('1);
    drain();
    write_count(COUNT_W'(2));
    idle_enable = 1'b1;
    for (int k = 0; k < 20; k++) queue_job(pick_duration());
    drain();

    $display("scheduled %0d jobs across %0d worker-count writes, idling and a long output hold",
             jobs_accepted, count_writes);
    $display("%0d grants started at the saturated free time, %0d mismatches",
             saturated_grants, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
